// ===== src/dns_query_message_builder_unit_assert.svh =====
// Assertion macros for the DNS query message builder checker.
// No dependencies; taken in by `include where assertions are written.
`ifndef DNS_QUERY_MESSAGE_BUILDER_UNIT_ASSERT_SVH
`define DNS_QUERY_MESSAGE_BUILDER_UNIT_ASSERT_SVH

// Clocked assertion with active-low reset as disable.
`define DQMB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form: antecedent overlaps consequent.
`define DQMB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    `DQMB_ASSERT(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== src/dqmb_pkg.sv =====
// Shared types, constants and byte tables of the DNS query message builder.
// No dependencies.
package dqmb_pkg;

    localparam int unsigned CNT_W = 6;

    localparam logic [7:0] DOT_CHAR   = 8'h2E;
    localparam logic [7:0] QTYPE_A    = 8'd1;
    localparam logic [7:0] QTYPE_AAAA = 8'd28;
    localparam logic [7:0] QCLASS_IN  = 8'd1;

    localparam logic [CNT_W-1:0] HDR_LAST  = 6'd11;
    localparam logic [CNT_W-1:0] TAIL_LAST = 6'd4;

    localparam logic [1:0] REG_QUERY_ID  = 2'd0;
    localparam logic [1:0] REG_RECURSION = 2'd1;
    localparam logic [1:0] REG_INVERSE   = 2'd2;
    localparam logic [1:0] REG_IPV6      = 2'd3;

    typedef logic [1:0] t_src;
    localparam t_src SRC_HDR  = 2'd0;
    localparam t_src SRC_LEN  = 2'd1;
    localparam t_src SRC_DATA = 2'd2;
    localparam t_src SRC_TAIL = 2'd3;

    typedef struct packed {
        logic             emit;
        t_src             src;
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] rd_idx;
        logic             run_end;
        logic             msg_end;
        logic             clr_label;
    } t_cmd;

    typedef struct packed {
        logic             out_free;
        logic             hdr_sent;
        logic             in_dot;
        logic             in_last;
        logic [CNT_W-1:0] fill;
    } t_sts;

    function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [15:0] qid,
                                            input logic rd, input logic iq);
        logic [7:0] b;
        case (idx)
            4'd0:    b = qid[15:8];
            4'd1:    b = qid[7:0];
            4'd2:    b = {4'b0000, iq, 2'b00, rd};
            4'd5:    b = 8'd1;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] tail_byte(input logic [2:0] idx, input logic v6);
        logic [7:0] b;
        case (idx)
            3'd2:    b = v6 ? QTYPE_AAAA : QTYPE_A;
            3'd4:    b = QCLASS_IN;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

// ===== src/dns_query_message_builder_unit.sv =====
// Channel   | Dir | Handshake          | Payload
// s (name)  | in  | tvalid/tready      | tdata = name_char, tlast = last_char
// m (bytes) | out | tvalid/tready      | tdata = out_byte, tlast = run_end, tuser = flags
// cfg       | in  | valid/ready        | index = register, data = value
//
// The byte sequencer drives one output register: 12 bytes for the header, a length
// byte plus the label characters for a label, and 5 bytes for the tail. Reset is
// synchronous, active low, and returns the control, label-fill and configuration
// registers to their defaults. A stall on the output holds the sequencer.
// Top level of the DNS query message builder; depends on dqmb_pkg, dqmb_ctrl, dqmb_dpath.
module dns_query_message_builder_unit #(
    parameter int unsigned MAX_LABEL = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] name_char
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] out_byte
    output logic        o_m_tlast,
    output logic [1:0]  o_m_tuser,   // [0] message_end, [1] label_truncated
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import dqmb_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_ready;
    logic w_accept;

    assign w_accept    = i_s_tvalid && w_ready;
    assign o_s_tready  = w_ready;
    assign o_cfg_ready = 1'b1;

    dqmb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_sts    (w_sts),
        .o_ready  (w_ready),
        .o_cmd    (w_cmd)
    );

    dqmb_dpath #(
        .MAX_LABEL (MAX_LABEL)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_char        (i_s_tdata),
        .i_last        (i_s_tlast),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (w_cmd),
        .i_out_ready   (i_m_tready),
        .o_sts         (w_sts),
        .o_out_valid   (o_m_tvalid),
        .o_out_byte    (o_m_tdata),
        .o_out_run_end (o_m_tlast),
        .o_out_msg_end (o_m_tuser[0]),
        .o_out_trunc   (o_m_tuser[1])
    );

endmodule

// ===== src/dqmb_ctrl.sv =====
// Sequencer of the DNS query message builder: header, length, label, tail.
// Depends on dqmb_pkg; drives the datapath through t_cmd, reads t_sts.
module dqmb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  dqmb_pkg::t_sts i_sts,
    output logic           o_ready,
    output dqmb_pkg::t_cmd o_cmd
);
    import dqmb_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_HDR  = 3'd1;
    localparam logic [2:0] ST_LEN  = 3'd2;
    localparam logic [2:0] ST_DATA = 3'd3;
    localparam logic [2:0] ST_TAIL = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_lbl, n_lbl;
    logic             r_tail, n_tail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_lbl   <= 1'b0;
            r_tail  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_lbl   <= n_lbl;
            r_tail  <= n_tail;
        end
    end

    assign o_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state         = r_state;
        n_cnt           = r_cnt;
        n_lbl           = r_lbl;
        n_tail          = r_tail;
        o_cmd.emit      = 1'b0;
        o_cmd.src       = SRC_HDR;
        o_cmd.cnt       = r_cnt;
        o_cmd.run_end   = 1'b0;
        o_cmd.msg_end   = 1'b0;
        o_cmd.clr_label = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    n_lbl  = i_sts.in_dot || i_sts.in_last;
                    n_tail = i_sts.in_last;
                    n_cnt  = '0;
                    if (!i_sts.hdr_sent) begin
                        n_state = ST_HDR;
                    end else if (i_sts.in_dot || i_sts.in_last) begin
                        n_state = ST_LEN;
                    end
                end
            end
            ST_HDR: begin
                o_cmd.src = SRC_HDR;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_cnt == HDR_LAST) begin
                        o_cmd.run_end = !r_lbl;
                        n_cnt         = '0;
                        n_state       = r_lbl ? ST_LEN : ST_IDLE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            ST_LEN: begin
                o_cmd.src = SRC_LEN;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_cnt      = '0;
                    if (i_sts.fill == '0) begin
                        o_cmd.run_end   = !r_tail;
                        o_cmd.clr_label = 1'b1;
                        n_state         = r_tail ? ST_TAIL : ST_IDLE;
                    end else begin
                        n_state = ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                o_cmd.src = SRC_DATA;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_cnt + 1'b1 == i_sts.fill) begin
                        o_cmd.run_end   = !r_tail;
                        o_cmd.clr_label = 1'b1;
                        n_cnt           = '0;
                        n_state         = r_tail ? ST_TAIL : ST_IDLE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            ST_TAIL: begin
                o_cmd.src = SRC_TAIL;
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_cnt == TAIL_LAST) begin
                        o_cmd.run_end = 1'b1;
                        o_cmd.msg_end = 1'b1;
                        n_cnt         = '0;
                        n_state       = ST_IDLE;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = '0;
            end
        endcase
        o_cmd.rd_idx = n_cnt;
    end

endmodule

// ===== src/dqmb_dpath.sv =====
// Datapath of the DNS query message builder: registers, label memory, output word.
// Depends on dqmb_pkg; steered by dqmb_ctrl through t_cmd.
module dqmb_dpath #(
    parameter int unsigned MAX_LABEL = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_char,
    input  logic           i_last,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_index,
    input  logic [15:0]    i_cfg_data,
    input  dqmb_pkg::t_cmd i_cmd,
    input  logic           i_out_ready,
    output dqmb_pkg::t_sts o_sts,
    output logic           o_out_valid,
    output logic [7:0]     o_out_byte,
    output logic           o_out_run_end,
    output logic           o_out_msg_end,
    output logic           o_out_trunc
);
    import dqmb_pkg::*;

    localparam int unsigned AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
    localparam int unsigned CW = $clog2(MAX_LABEL + 1);

    logic [15:0]   r_qid;
    logic          r_rd_flag;
    logic          r_iq_flag;
    logic          r_v6;
    logic          r_hdr_sent;
    logic [CW-1:0] r_fill;
    logic          r_ovf;
    logic [7:0]    r_mem [MAX_LABEL];
    logic [7:0]    r_rd_data;
    logic          r_valid;
    logic [7:0]    r_byte;
    logic          r_run_end;
    logic          r_msg_end;
    logic          r_trunc;

    logic          w_dot;
    logic          w_room;
    logic [7:0]    w_byte;

    assign w_dot  = (i_char == DOT_CHAR);
    assign w_room = (r_fill < CW'(MAX_LABEL));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qid     <= 16'd45;
            r_rd_flag <= 1'b0;
            r_iq_flag <= 1'b0;
            r_v6      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_QUERY_ID:  r_qid     <= i_cfg_data;
                REG_RECURSION: r_rd_flag <= i_cfg_data[0];
                REG_INVERSE:   r_iq_flag <= i_cfg_data[0];
                REG_IPV6:      r_v6      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_sent <= 1'b0;
            r_fill     <= '0;
            r_ovf      <= 1'b0;
        end else begin
            if (i_accept) begin
                r_hdr_sent <= !i_last;
                if (!w_dot) begin
                    if (w_room) begin
                        r_fill <= r_fill + 1'b1;
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
            end else if (i_cmd.clr_label) begin
                r_fill <= '0;
                r_ovf  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && !w_dot && w_room) begin
            r_mem[r_fill[AW-1:0]] <= i_char;
        end
        r_rd_data <= r_mem[i_cmd.rd_idx[AW-1:0]];
    end

    always_comb begin
        case (i_cmd.src)
            SRC_HDR:  w_byte = hdr_byte(i_cmd.cnt[3:0], r_qid, r_rd_flag, r_iq_flag);
            SRC_LEN:  w_byte = 8'(r_fill);
            SRC_DATA: w_byte = r_rd_data;
            default:  w_byte = tail_byte(i_cmd.cnt[2:0], r_v6);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_byte    <= w_byte;
            r_run_end <= i_cmd.run_end;
            r_msg_end <= i_cmd.msg_end;
            r_trunc   <= (i_cmd.src == SRC_LEN) && r_ovf;
        end
    end

    assign o_sts.out_free = !r_valid || i_out_ready;
    assign o_sts.hdr_sent = r_hdr_sent;
    assign o_sts.in_dot   = w_dot;
    assign o_sts.in_last  = i_last;
    assign o_sts.fill     = CNT_W'(r_fill);

    assign o_out_valid   = r_valid;
    assign o_out_byte    = r_byte;
    assign o_out_run_end = r_run_end;
    assign o_out_msg_end = r_msg_end;
    assign o_out_trunc   = r_trunc;

endmodule

// ===== src/dqmb_checker.sv =====
// Port-level checker of the DNS query message builder, bound to the top level.
// Depends on dns_query_message_builder_unit_assert.svh.
`include "dns_query_message_builder_unit_assert.svh"

module dqmb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast,
    input logic [1:0] o_m_tuser
);

    logic w_end;
    logic w_cut;
    logic w_mid;
    logic w_stall;

    assign w_end   = o_m_tvalid && o_m_tuser[0];
    assign w_cut   = o_m_tvalid && o_m_tuser[1];
    assign w_mid   = !o_m_tlast && !o_m_tuser[0];
    assign w_stall = o_m_tvalid && !i_m_tready;

    `DQMB_ASSERT_IMP(a_end_tlast, i_clk, i_rst_n, w_end, o_m_tlast, "end word without tlast")
    `DQMB_ASSERT_IMP(a_end_class, i_clk, i_rst_n, w_end, o_m_tdata == 8'h01, "end word not QCLASS")
    `DQMB_ASSERT_IMP(a_cut_mid_run, i_clk, i_rst_n, w_cut, w_mid, "cut length word ends a run")
    `DQMB_ASSERT(a_hold, i_clk, i_rst_n, w_stall |=> o_m_tvalid && $stable(o_m_tdata), "word moved")

endmodule

bind dns_query_message_builder_unit dqmb_checker u_dqmb_checker (.*);
